// File: sv/pdc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; every other file but pdc_in_reg imports this package.
`timescale 1ns / 1ps

package pdc_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'hC3;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_CHUNKS  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CRC_LO  = 3'd6,
        PH_CRC_HI  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_LEN_ERR = 2'd2
    } status_t;

    // One result word as it leaves the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] chunks_left;
        logic       payload_flag;
        logic       frame_end;
        status_t    frame_status;
    } result_t;

    // CCITT-FALSE update for one byte, MSB first; unrolls to an xor network.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOPBIT) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: sv/pdc_in_reg.sv
// Input register stage of the packet deframer: holds one received word.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module pdc_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       taken,
    input  logic [7:0] rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (taken)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= rx_byte;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: sv/pdc_parser.sv
// Frame parser of the packet deframer: phase machine, length check and CRC.
// Depends on pdc_pkg for the phase and status codes and the CRC function.
`timescale 1ns / 1ps

module pdc_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data,
    input  logic            fire,
    input  logic [7:0]      byte_data,
    output pdc_pkg::result_t result
);

    import pdc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  chunks_reg, chunks_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] max_len_reg;

    logic [15:0] len_full;
    logic        len_over;
    logic [15:0] seen_inc;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;

    assign len_full = {byte_data, len_reg[7:0]};
    assign len_over = len_full > max_len_reg;
    assign seen_inc = seen_reg + 16'd1;
    assign crc_upd  = crc16_byte(crc_reg, byte_data);
    assign rx_crc   = {byte_data, crc_lo_reg};

    // Next state of the phase machine and the frame context.
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        type_next   = type_reg;
        chunks_next = chunks_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_data == SYNC_BYTE)
                    begin
                        type_next   = 8'h00;
                        chunks_next = 8'h00;
                        crc_next    = CRC_INIT;
                        seen_next   = 16'h0000;
                        phase_next  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'h00, byte_data};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = len_full;
                    phase_next = len_over ? PH_HUNT : PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = byte_data;
                    phase_next = PH_CHUNKS;
                end
                PH_CHUNKS:
                begin
                    chunks_next = byte_data;
                    seen_next   = 16'h0000;
                    phase_next  = (len_reg == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    crc_next  = crc_upd;
                    seen_next = seen_inc;
                    if (seen_inc >= len_reg)
                        phase_next = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = byte_data;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Result word for the byte being consumed.
    always_comb
    begin
        result              = '0;
        result.frame_type   = type_reg;
        result.chunks_left  = chunks_reg;
        result.frame_status = ST_GOOD;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                if (len_over)
                begin
                    result.valid        = fire;
                    result.frame_end    = 1'b1;
                    result.frame_status = ST_LEN_ERR;
                end
            end
            PH_PAYLOAD:
            begin
                result.valid        = fire;
                result.data_byte    = byte_data;
                result.payload_flag = 1'b1;
            end
            PH_CRC_HI:
            begin
                result.valid        = fire;
                result.frame_end    = 1'b1;
                result.frame_status = (rx_crc == crc_reg) ? ST_GOOD : ST_CRC_ERR;
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            len_reg     <= 16'h0000;
            seen_reg    <= 16'h0000;
            type_reg    <= 8'h00;
            chunks_reg  <= 8'h00;
            crc_reg     <= CRC_INIT;
            crc_lo_reg  <= 8'h00;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            type_reg   <= type_next;
            chunks_reg <= chunks_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
        end
    end

endmodule

// File: sv/pdc_out_reg.sv
// Result register of the packet deframer: holds one word for the output channel.
// Depends on pdc_pkg for the result word type.
`timescale 1ns / 1ps

module pdc_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  pdc_pkg::result_t result,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             out_free,
    output pdc_pkg::result_t held
);

    import pdc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        if (result.valid)
            valid_next = 1'b1;
        else if (out_free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
            word_reg <= result;
    end

    assign out_valid = valid_reg;
    assign held      = word_reg;

endmodule

// File: sv/packet_deframer_crc16_top.sv
// A word is registered in the input register, consumed by the parser and its result, if
// any, registered in the result register. Throughput: one word per cycle while the output
// is not stalled, limited by the phase machine and bytewise CRC update between registers.
// Reset (asynchronous, active low) empties both registers, returns the parser
// to sync hunt and sets the length limit to 65535.
`timescale 1ns / 1ps

module packet_deframer_crc16_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_type,
    output logic [7:0]  chunks_left,
    output logic        payload_flag,
    output logic        frame_end,
    output logic [1:0]  frame_status
);

    import pdc_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       fire;
    result_t    result;
    result_t    held;

    // The parser consumes a word only when the result register can take it.
    assign fire     = byte_valid && out_free;
    assign in_stall = byte_valid && !fire;

    pdc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_valid && !in_stall),
        .taken      (fire),
        .rx_byte    (rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    pdc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .byte_data   (byte_data),
        .result      (result)
    );

    pdc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_free  (out_free),
        .held      (held)
    );

    assign data_byte    = held.data_byte;
    assign frame_type   = held.frame_type;
    assign chunks_left  = held.chunks_left;
    assign payload_flag = held.payload_flag;
    assign frame_end    = held.frame_end;
    assign frame_status = 2'(held.frame_status);

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(payload_flag && frame_end))
        else $error("result is both payload and frame end");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_flag) |-> (frame_status == ST_GOOD))
        else $error("payload word carries an error status");

    a_len_err_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status == ST_LEN_ERR) |->
            (frame_type == 8'h00 && chunks_left == 8'h00 && frame_end))
        else $error("length error carries header fields");

endmodule

// File: tb/sv/packet_deframer_crc16_top_tb.sv
// Self-checking testbench for packet_deframer_crc16_top: random framed byte streams
// with random gaps and stalls, checked against a built-in parser with its own CRC-16.
// Depends on pdc_pkg (phase and status enums, sync byte, CRC constants) and the top level.
`timescale 1ns / 1ps

module packet_deframer_crc16_top_tb;

    import pdc_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] chunks_left;
        logic       payload_flag;
        logic       frame_end;
        status_t    frame_status;
    } deframed_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [7:0]  chunks_left;
    logic        payload_flag;
    logic        frame_end;
    logic [1:0]  frame_status;

    // Link bytes waiting to be sent, and words the parser owes.
    logic [7:0]     link_bytes[$];
    deframed_word_t expected_words[$];

    // Parser state tracked by the testbench.
    logic [15:0] limit_len = MAX_LEN_RESET;
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] rx_len = 16'h0000;
    logic [15:0] rx_seen = 16'h0000;
    logic [7:0]  rx_type = 8'h00;
    logic [7:0]  rx_chunks = 8'h00;
    logic [15:0] rx_crc = CRC_INIT;
    logic [7:0]  rx_crc_lo = 8'h00;

    int error_count = 0;
    int bytes_queued = 0;
    int words_accepted = 0;
    int words_checked = 0;
    int frames_good = 0;
    int frames_crc_bad = 0;
    int frames_too_long = 0;
    int source_hold = 0;
    int source_calm = 0;
    int sink_hold = 0;
    int sink_calm = 0;

    packet_deframer_crc16_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .frame_type   (frame_type),
        .chunks_left  (chunks_left),
        .payload_flag (payload_flag),
        .frame_end    (frame_end),
        .frame_status (frame_status)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Bit-serial form of the CCITT update: feedback is the top bit xor the data bit.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Occasionally starts a calm stretch with no waits, otherwise draws a random wait per word.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic owe_word(input logic [7:0] data, input logic pflag, input logic fend,
                            input status_t status);
        deframed_word_t w;
        w.data_byte    = data;
        w.frame_type   = rx_type;
        w.chunks_left  = rx_chunks;
        w.payload_flag = pflag;
        w.frame_end    = fend;
        w.frame_status = status;
        expected_words.push_back(w);
    endtask

    // Advances the tracked parser by one accepted link byte.
    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] got_crc;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == SYNC_BYTE)
                begin
                    rx_type = 8'h00;
                    rx_chunks = 8'h00;
                    rx_crc = CRC_INIT;
                    rx_seen = 16'h0000;
                    rx_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                rx_len = {8'h00, b};
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                rx_len = {b, rx_len[7:0]};
                if (rx_len > limit_len)
                begin
                    rx_phase = PH_HUNT;
                    frames_too_long++;
                    owe_word(8'h00, 1'b0, 1'b1, ST_LEN_ERR);
                end
                else
                    rx_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                rx_type = b;
                rx_phase = PH_CHUNKS;
            end
            PH_CHUNKS:
            begin
                rx_chunks = b;
                rx_seen = 16'h0000;
                rx_phase = (rx_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                rx_crc = crc_step(rx_crc, b);
                rx_seen = rx_seen + 16'd1;
                if (rx_seen >= rx_len)
                    rx_phase = PH_CRC_LO;
                owe_word(b, 1'b1, 1'b0, ST_GOOD);
            end
            PH_CRC_LO:
            begin
                rx_crc_lo = b;
                rx_phase = PH_CRC_HI;
            end
            default:
            begin
                got_crc = {b, rx_crc_lo};
                rx_phase = PH_HUNT;
                if (got_crc == rx_crc)
                    frames_good++;
                else
                    frames_crc_bad++;
                owe_word(8'h00, 1'b0, 1'b1, (got_crc == rx_crc) ? ST_GOOD : ST_CRC_ERR);
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_len_only(input logic [15:0] len);
        queue_byte(SYNC_BYTE);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] chunks,
                              input byte_q_t body, input bit bad_crc);
        logic [15:0] crc;
        logic [15:0] n;
        crc = CRC_INIT;
        n = 16'(body.size());
        send_len_only(n);
        queue_byte(ftype);
        queue_byte(chunks);
        foreach (body[i])
        begin
            queue_byte(body[i]);
            crc = crc_step(crc, body[i]);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        queue_byte(crc[7:0]);
        queue_byte(crc[15:8]);
    endtask

    // Mostly well-formed frames; the rest is line noise, over-length headers and bad CRCs.
    task automatic send_random_frame();
        byte_q_t    body;
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 4))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == SYNC_BYTE)
                    b = ~b;
                queue_byte(b);
            end
        end
        else if (pick < 20 && limit_len != 16'hFFFF)
        begin
            if ($urandom_range(0, 1) == 0)
                send_len_only(limit_len + 16'd1);
            else
                send_len_only(16'($urandom_range(int'(limit_len) + 1, 65535)));
        end
        else
        begin
            n = $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0)
                n = $urandom_range(13, 300);
            if (n > int'(limit_len))
                n = int'(limit_len);
            repeat (n)
                body.push_back(($urandom_range(0, 15) == 0) ? SYNC_BYTE
                                                            : 8'($urandom_range(0, 255)));
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), body,
                       $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic fill_phase(input int n_bytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
            send_random_frame();
    endtask

    // Waits until every byte is taken and every owed word has come out (reporting any that
    // never arrive), then lets the pipeline settle so that no header byte is still in flight.
    task automatic drain();
        int waited;
        waited = 0;
        do
            @(negedge clk);
        while (link_bytes.size() != 0 || in_valid);
        while (expected_words.size() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_words.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_words.size()));
            expected_words.delete();
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_len = value;
    endtask

    // Source side: one word per handshake, random gap before each new word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                deframe_byte(rx_byte);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (source_hold > 0)
                begin
                    source_hold--;
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() > 0)
                begin
                    rx_byte <= link_bytes.pop_front();
                    in_valid <= 1'b1;
                    source_hold = draw_wait(source_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Sink side: check each accepted word, then stall for a random while.
    always @(posedge clk)
    begin : sink
        deframed_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word data %02h end %0b status %0d",
                                              data_byte, frame_end, frame_status));
                else
                begin
                    want = expected_words.pop_front();
                    if (data_byte !== want.data_byte || frame_type !== want.frame_type ||
                        chunks_left !== want.chunks_left ||
                        payload_flag !== want.payload_flag ||
                        frame_end !== want.frame_end || frame_status !== want.frame_status)
                        report_mismatch($sformatf(
                            {"got d%02h t%02h c%02h p%0b e%0b s%0d, ",
                             "want d%02h t%02h c%02h p%0b e%0b s%0d"},
                            data_byte, frame_type, chunks_left, payload_flag, frame_end,
                            frame_status, want.data_byte, want.frame_type, want.chunks_left,
                            want.payload_flag, want.frame_end, want.frame_status));
                end
                sink_hold = draw_wait(sink_calm);
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        byte_q_t body;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limit: noise while hunting, a sync byte and 0xFF inside the payload,
        // an empty frame, and a frame whose CRC is off.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        body = '{SYNC_BYTE, 8'hFF};
        send_frame(8'hFF, 8'h00, body, 1'b0);
        body.delete();
        send_frame(8'h00, 8'hFF, body, 1'b0);
        body = '{8'h00};
        send_frame(8'h5A, 8'hA5, body, 1'b1);
        fill_phase(200);
        drain();

        // Zero limit: every nonempty frame is refused on its second length byte.
        write_limit(16'h0000);
        send_len_only(16'h0001);
        send_len_only(16'hFFFF);
        body.delete();
        send_frame(8'hA5, 8'h5A, body, 1'b0);
        send_frame(8'h3C, 8'hC3, body, 1'b1);
        fill_phase(150);
        drain();

        write_limit(16'd8);
        fill_phase(200);
        drain();

        write_limit(16'hFFFF);
        fill_phase(150);
        drain();

        write_limit(16'($urandom_range(1, 300)));
        fill_phase(150);
        drain();

        $display("Sent %0d link bytes under five length limits; %0d output words checked.",
                 words_accepted, words_checked);
        $display("Frames closed: %0d good, %0d with CRC errors, %0d over the length limit.",
                 frames_good, frames_crc_bad, frames_too_long);
        if (error_count == 0)
            $display("** packet_deframer_crc16_top: PASSED **");
        else
            $display("** packet_deframer_crc16_top: FAILED **");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Timed out with %0d words still expected.", expected_words.size());
        $display("** packet_deframer_crc16_top: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/pdc_pkg.sv
sv/pdc_in_reg.sv
sv/pdc_parser.sv
sv/pdc_out_reg.sv
sv/packet_deframer_crc16_top.sv
tb/sv/packet_deframer_crc16_top_tb.sv
